@@ src/lte_pkg.sv @@
// ----------------------------------------------------------------------------
// lte_pkg
// shared widths, codes, reset values and the pixel type of the led
// transition engine
// ----------------------------------------------------------------------------
package lte_pkg;

    localparam int DEFAULT_MAX_LEDS = 512;

    localparam int CHAN_W   = 8;
    localparam int FUNC_W   = 2;
    localparam int INDEX_W  = 9;
    localparam int BRIGHT_W = 8;
    localparam int FRAMES_W = 16;
    localparam int COUNT_W  = 10;
    localparam int REG_W    = 3;
    localparam int DATA_W   = 16;

    localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FADE   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_BRIGHT = 2'd3;

    localparam logic [REG_W-1:0] REG_TARGET_RED    = 3'd0;
    localparam logic [REG_W-1:0] REG_TARGET_GREEN  = 3'd1;
    localparam logic [REG_W-1:0] REG_TARGET_BLUE   = 3'd2;
    localparam logic [REG_W-1:0] REG_FADE_AMOUNT   = 3'd3;
    localparam logic [REG_W-1:0] REG_TARGET_BRIGHT = 3'd4;
    localparam logic [REG_W-1:0] REG_RAMP_FRAMES   = 3'd5;
    localparam logic [REG_W-1:0] REG_PIXEL_SPAN    = 3'd6;

    localparam logic [CHAN_W-1:0]   RST_FADE_AMOUNT   = 8'd2;
    localparam logic [BRIGHT_W-1:0] RST_TARGET_BRIGHT = 8'd255;
    localparam logic [FRAMES_W-1:0] RST_RAMP_FRAMES   = 16'd60;
    localparam logic [COUNT_W-1:0]  RST_PIXEL_SPAN    = 10'd64;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

endpackage

@@ src/lte_if.sv @@
// ----------------------------------------------------------------------------
// lte interfaces
// command, response and configuration channels of the led transition engine
// ----------------------------------------------------------------------------
interface lte_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [lte_pkg::FUNC_W-1:0]    func;
    logic [lte_pkg::INDEX_W-1:0]   pixel_index;
    logic [lte_pkg::CHAN_W-1:0]    write_red;
    logic [lte_pkg::CHAN_W-1:0]    write_green;
    logic [lte_pkg::CHAN_W-1:0]    write_blue;

    modport source (output valid, func, pixel_index, write_red, write_green, write_blue,
                    input ready);
    modport sink (input valid, func, pixel_index, write_red, write_green, write_blue,
                  output ready);
endinterface

interface lte_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [lte_pkg::CHAN_W-1:0]    read_red;
    logic [lte_pkg::CHAN_W-1:0]    read_green;
    logic [lte_pkg::CHAN_W-1:0]    read_blue;
    logic [lte_pkg::BRIGHT_W-1:0]  brightness_now;
    logic                          colour_done;
    logic                          ramp_done;

    modport source (output valid, read_red, read_green, read_blue, brightness_now,
                    colour_done, ramp_done, input ready);
    modport sink (input valid, read_red, read_green, read_blue, brightness_now,
                  colour_done, ramp_done, output ready);
endinterface

interface lte_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [lte_pkg::REG_W-1:0]     index;
    logic [lte_pkg::DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ src/led_transition_engine.sv @@
// ----------------------------------------------------------------------------
// led_transition_engine
// pixel memory with fade toward a target colour and a brightness ramp
// ----------------------------------------------------------------------------
// After reset the engine sweeps the pixel memory to black, one pixel a cycle,
// and takes no command until the last pixel is cleared; configuration writes
// are taken at any time. Commands run one at a time. A pixel write goes from
// idle to the result state, a pixel read through the read state first, as
// the memory's read is registered. A fade step streams the pixels in use
// (the pixel count register, capped at MAX_LEDS) through a read, update and
// write-back pipeline at one pixel a cycle. A brightness step waits on the
// bit-serial divider while the ramp runs, not once the ramp is over. A finished
// response waits in the output register while the next command is taken.
// ----------------------------------------------------------------------------
module led_transition_engine #(
    parameter int MAX_LEDS = lte_pkg::DEFAULT_MAX_LEDS
) (
    input  logic         clk,
    input  logic         rst_n,
    lte_cmd_if.sink      cmd,
    lte_rsp_if.source    rsp,
    lte_cfg_if.sink      cfg
);

    localparam int ADDR_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int CNT_W  = $clog2(MAX_LEDS + 1);
    localparam int CMP_W  = (CNT_W > lte_pkg::COUNT_W) ? CNT_W : lte_pkg::COUNT_W;
    localparam int BW     = lte_pkg::BRIGHT_W;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_FADE   = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_RESULT = 3'd5;

    logic [2:0]                      state_reg, state_next;
    logic [ADDR_W-1:0]               clr_cnt_reg, clr_cnt_next;
    lte_pkg::pixel_t                 tgt_reg, tgt_next;
    logic [lte_pkg::CHAN_W-1:0]      amount_reg, amount_next;
    logic [BW-1:0]                   tgt_bright_reg, tgt_bright_next;
    logic [lte_pkg::FRAMES_W-1:0]    frames_reg, frames_next;
    logic [lte_pkg::COUNT_W-1:0]     led_cnt_reg, led_cnt_next;
    logic [BW-1:0]                   bright_reg, bright_next;
    logic [lte_pkg::FRAMES_W-1:0]    ramp_cnt_reg, ramp_cnt_next;
    logic                            cdone_reg, cdone_next;
    logic                            rdone_reg, rdone_next;
    logic [CMP_W-1:0]                issue_cnt_reg, issue_cnt_next;
    logic [CMP_W-1:0]                fade_n_reg, fade_n_next;
    logic                            pipe_valid_reg, pipe_valid_next;
    logic [ADDR_W-1:0]               pipe_addr_reg, pipe_addr_next;
    logic                            match_reg, match_next;
    lte_pkg::pixel_t                 rd_hold_reg, rd_hold_next;
    logic                            rd_ok_reg, rd_ok_next;
    logic                            neg_reg, neg_next;
    logic                            out_valid_reg, out_valid_next;
    lte_pkg::pixel_t                 out_pix_reg, out_pix_next;
    logic [BW-1:0]                   out_bright_reg, out_bright_next;
    logic                            out_cdone_reg, out_cdone_next;
    logic                            out_rdone_reg, out_rdone_next;

    logic                            mem_we;
    logic [ADDR_W-1:0]               mem_waddr;
    lte_pkg::pixel_t                 mem_wdata;
    logic [ADDR_W-1:0]               mem_raddr;
    lte_pkg::pixel_t                 mem_rdata;

    lte_pkg::pixel_t                 fade_nxt;
    logic                            fade_match;

    logic                            div_start;
    logic                            div_done;
    logic [BW-1:0]                   div_quo;
    logic [BW:0]                     bdiff;
    logic [BW-1:0]                   bmag;
    logic [lte_pkg::FRAMES_W-1:0]    frames_left;
    logic [BW+1:0]                   bsum;

    logic                            cmd_fire;
    logic [CMP_W-1:0]                idx_ext;
    logic                            idx_ok;
    logic [ADDR_W-1:0]               idx_addr;
    logic [CMP_W-1:0]                n_clamped;
    logic                            issue;
    logic                            out_free;

    lte_pixel_mem #(
        .DEPTH  (MAX_LEDS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    lte_fade_calc u_fade (
        .cur    (mem_rdata),
        .tgt    (tgt_reg),
        .amount (amount_reg),
        .nxt    (fade_nxt),
        .match  (fade_match)
    );

    lte_ramp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (bmag),
        .divisor  (frames_left),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign cmd.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign cmd_fire  = cmd.valid && cmd.ready;

    assign idx_ext   = CMP_W'(cmd.pixel_index);
    assign idx_ok    = (idx_ext < CMP_W'(MAX_LEDS));
    assign idx_addr  = idx_ext[ADDR_W-1:0];
    assign n_clamped = (CMP_W'(led_cnt_reg) > CMP_W'(MAX_LEDS))
                       ? CMP_W'(MAX_LEDS) : CMP_W'(led_cnt_reg);
    assign issue     = (issue_cnt_reg != fade_n_reg);
    assign out_free  = !out_valid_reg || rsp.ready;

    assign bdiff       = {1'b0, tgt_bright_reg} - {1'b0, bright_reg};
    assign bmag        = bdiff[BW] ? BW'(-bdiff) : bdiff[BW-1:0];
    assign frames_left = frames_reg - ramp_cnt_reg;
    assign bsum        = neg_reg ? ({2'b00, bright_reg} - {2'b00, div_quo})
                                 : ({2'b00, bright_reg} + {2'b00, div_quo});

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        tgt_next        = tgt_reg;
        amount_next     = amount_reg;
        tgt_bright_next = tgt_bright_reg;
        frames_next     = frames_reg;
        led_cnt_next    = led_cnt_reg;
        bright_next     = bright_reg;
        ramp_cnt_next   = ramp_cnt_reg;
        cdone_next      = cdone_reg;
        rdone_next      = rdone_reg;
        issue_cnt_next  = issue_cnt_reg;
        fade_n_next     = fade_n_reg;
        pipe_valid_next = 1'b0;
        pipe_addr_next  = pipe_addr_reg;
        match_next      = match_reg;
        rd_hold_next    = rd_hold_reg;
        rd_ok_next      = rd_ok_reg;
        neg_next        = neg_reg;
        out_valid_next  = out_valid_reg;
        out_pix_next    = out_pix_reg;
        out_bright_next = out_bright_reg;
        out_cdone_next  = out_cdone_reg;
        out_rdone_next  = out_rdone_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        mem_raddr       = issue_cnt_reg[ADDR_W-1:0];
        div_start       = 1'b0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                if (clr_cnt_reg == ADDR_W'(MAX_LEDS - 1))
                    state_next = S_IDLE;
                else
                    clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    rd_hold_next = '0;
                    case (cmd.func)
                        lte_pkg::FUNC_WRITE:
                        begin
                            mem_we          = idx_ok;
                            mem_waddr       = idx_addr;
                            mem_wdata.red   = cmd.write_red;
                            mem_wdata.green = cmd.write_green;
                            mem_wdata.blue  = cmd.write_blue;
                            state_next      = S_RESULT;
                        end
                        lte_pkg::FUNC_READ:
                        begin
                            mem_raddr  = idx_addr;
                            rd_ok_next = idx_ok;
                            state_next = S_READ;
                        end
                        lte_pkg::FUNC_FADE:
                        begin
                            if (n_clamped == '0)
                            begin
                                cdone_next = 1'b1;
                                state_next = S_RESULT;
                            end
                            else
                            begin
                                issue_cnt_next = '0;
                                fade_n_next    = n_clamped;
                                match_next     = 1'b1;
                                state_next     = S_FADE;
                            end
                        end
                        default:
                        begin
                            if (ramp_cnt_reg < frames_reg)
                            begin
                                div_start  = 1'b1;
                                neg_next   = bdiff[BW];
                                state_next = S_DIV;
                            end
                            else
                            begin
                                rdone_next = 1'b1;
                                state_next = S_RESULT;
                            end
                        end
                    endcase
                end
            end
            S_READ:
            begin
                rd_hold_next = rd_ok_reg ? mem_rdata : '0;
                state_next   = S_RESULT;
            end
            S_FADE:
            begin
                if (issue)
                begin
                    issue_cnt_next  = issue_cnt_reg + 1'b1;
                    pipe_valid_next = 1'b1;
                    pipe_addr_next  = issue_cnt_reg[ADDR_W-1:0];
                end
                if (pipe_valid_reg)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = pipe_addr_reg;
                    mem_wdata  = fade_nxt;
                    match_next = match_reg && fade_match;
                    if (!issue)
                    begin
                        cdone_next = match_reg && fade_match;
                        state_next = S_RESULT;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (bsum[BW+1])
                        bright_next = '0;
                    else if (bsum[BW])
                        bright_next = '1;
                    else
                        bright_next = bsum[BW-1:0];
                    ramp_cnt_next = ramp_cnt_reg + 1'b1;
                    rdone_next    = 1'b0;
                    state_next    = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_pix_next    = rd_hold_reg;
                    out_bright_next = bright_reg;
                    out_cdone_next  = cdone_reg;
                    out_rdone_next  = rdone_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg.valid)
        begin
            case (cfg.index)
                lte_pkg::REG_TARGET_RED:    tgt_next.red     = cfg.data[lte_pkg::CHAN_W-1:0];
                lte_pkg::REG_TARGET_GREEN:  tgt_next.green   = cfg.data[lte_pkg::CHAN_W-1:0];
                lte_pkg::REG_TARGET_BLUE:   tgt_next.blue    = cfg.data[lte_pkg::CHAN_W-1:0];
                lte_pkg::REG_FADE_AMOUNT:   amount_next      = cfg.data[lte_pkg::CHAN_W-1:0];
                lte_pkg::REG_TARGET_BRIGHT: tgt_bright_next  = cfg.data[BW-1:0];
                lte_pkg::REG_RAMP_FRAMES:   frames_next      = cfg.data;
                lte_pkg::REG_PIXEL_SPAN:    led_cnt_next     = cfg.data[lte_pkg::COUNT_W-1:0];
                default:                    ;
            endcase
            if (cfg.index inside {lte_pkg::REG_TARGET_RED, lte_pkg::REG_TARGET_GREEN,
                                  lte_pkg::REG_TARGET_BLUE, lte_pkg::REG_FADE_AMOUNT,
                                  lte_pkg::REG_TARGET_BRIGHT, lte_pkg::REG_RAMP_FRAMES,
                                  lte_pkg::REG_PIXEL_SPAN})
            begin
                ramp_cnt_next = '0;
                cdone_next    = 1'b0;
                rdone_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            tgt_reg        <= '0;
            amount_reg     <= lte_pkg::RST_FADE_AMOUNT;
            tgt_bright_reg <= lte_pkg::RST_TARGET_BRIGHT;
            frames_reg     <= lte_pkg::RST_RAMP_FRAMES;
            led_cnt_reg    <= lte_pkg::RST_PIXEL_SPAN;
            bright_reg     <= '0;
            ramp_cnt_reg   <= '0;
            cdone_reg      <= 1'b0;
            rdone_reg      <= 1'b0;
            issue_cnt_reg  <= '0;
            fade_n_reg     <= '0;
            pipe_valid_reg <= 1'b0;
            match_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            tgt_reg        <= tgt_next;
            amount_reg     <= amount_next;
            tgt_bright_reg <= tgt_bright_next;
            frames_reg     <= frames_next;
            led_cnt_reg    <= led_cnt_next;
            bright_reg     <= bright_next;
            ramp_cnt_reg   <= ramp_cnt_next;
            cdone_reg      <= cdone_next;
            rdone_reg      <= rdone_next;
            issue_cnt_reg  <= issue_cnt_next;
            fade_n_reg     <= fade_n_next;
            pipe_valid_reg <= pipe_valid_next;
            match_reg      <= match_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pipe_addr_reg  <= pipe_addr_next;
        rd_hold_reg    <= rd_hold_next;
        rd_ok_reg      <= rd_ok_next;
        neg_reg        <= neg_next;
        out_pix_reg    <= out_pix_next;
        out_bright_reg <= out_bright_next;
        out_cdone_reg  <= out_cdone_next;
        out_rdone_reg  <= out_rdone_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.read_red       = out_pix_reg.red;
    assign rsp.read_green     = out_pix_reg.green;
    assign rsp.read_blue      = out_pix_reg.blue;
    assign rsp.brightness_now = out_bright_reg;
    assign rsp.colour_done    = out_cdone_reg;
    assign rsp.ramp_done      = out_rdone_reg;

endmodule

@@ src/lte_pixel_mem.sv @@
// ----------------------------------------------------------------------------
// lte_pixel_mem
// pixel memory, one write and one registered read port
// ----------------------------------------------------------------------------
module lte_pixel_mem #(
    parameter int DEPTH  = lte_pkg::DEFAULT_MAX_LEDS,
    parameter int ADDR_W = 9
) (
    input  logic                clk,
    input  logic                we,
    input  logic [ADDR_W-1:0]   waddr,
    input  lte_pkg::pixel_t     wdata,
    input  logic [ADDR_W-1:0]   raddr,
    output lte_pkg::pixel_t     rdata
);

    lte_pkg::pixel_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ src/lte_fade_calc.sv @@
// ----------------------------------------------------------------------------
// lte_fade_calc
// one fade step of a pixel toward the target colour, with match detect
// ----------------------------------------------------------------------------
module lte_fade_calc (
    input  lte_pkg::pixel_t                 cur,
    input  lte_pkg::pixel_t                 tgt,
    input  logic [lte_pkg::CHAN_W-1:0]      amount,
    output lte_pkg::pixel_t                 nxt,
    output logic                            match
);

    function automatic logic [lte_pkg::CHAN_W-1:0] approach(
        input logic [lte_pkg::CHAN_W-1:0] c,
        input logic [lte_pkg::CHAN_W-1:0] t,
        input logic [lte_pkg::CHAN_W-1:0] s
    );
        logic [lte_pkg::CHAN_W-1:0]   gap;
        logic [2*lte_pkg::CHAN_W-1:0] prod;
        logic [lte_pkg::CHAN_W-1:0]   step;
        begin
            gap  = (c < t) ? (t - c) : (c - t);
            prod = gap * s;
            step = prod[2*lte_pkg::CHAN_W-1:lte_pkg::CHAN_W]
                   + lte_pkg::CHAN_W'((gap != '0) && (s != '0));
            if (c < t)
                approach = c + step;
            else
                approach = c - step;
        end
    endfunction

    always_comb
    begin
        nxt.red   = approach(cur.red, tgt.red, amount);
        nxt.green = approach(cur.green, tgt.green, amount);
        nxt.blue  = approach(cur.blue, tgt.blue, amount);
        match     = (nxt == tgt);
    end

endmodule

@@ src/lte_ramp_div.sv @@
// ----------------------------------------------------------------------------
// lte_ramp_div
// restoring divider for the ramp step, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lte_ramp_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [lte_pkg::BRIGHT_W-1:0]        dividend,
    input  logic [lte_pkg::FRAMES_W-1:0]        divisor,
    output logic                                done,
    output logic [lte_pkg::BRIGHT_W-1:0]        quotient
);

    localparam int QW = lte_pkg::BRIGHT_W;
    localparam int DW = lte_pkg::FRAMES_W;
    localparam int CW = $clog2(QW + 1);

    logic [DW-1:0] rem_reg, rem_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic [DW-1:0] dsr_reg, dsr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          fits;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[QW-1]};
        diff      = trial - {1'b0, dsr_reg};
        fits      = (trial >= {1'b0, dsr_reg});
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DW-1:0] : trial[DW-1:0];
            quo_next = {quo_reg[QW-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(QW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
